/* rtl/blocked_class_reorder_index_map_macros.svh */
// Assertion macros shared by the blocked class reorder index map RTL
`ifndef BLOCKED_CLASS_REORDER_INDEX_MAP_MACROS_SVH
`define BLOCKED_CLASS_REORDER_INDEX_MAP_MACROS_SVH

// Property must hold at every clock edge outside reset
`define BCRIM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset
`define BCRIM_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* rtl/bcrim_pkg.sv */
// Shared constants, types and helpers for the blocked class reorder index map
package bcrim_pkg;

   localparam int MaxGroups   = 8;
   localparam int NumClasses  = 5;
   localparam int TableDepth  = MaxGroups * NumClasses;
   localparam int MaxOrbitals = 1024;

   localparam int AddrW  = $clog2(TableDepth);
   localparam int GrpW   = 3;
   localparam int ClsW   = 3;
   localparam int CountW = 11;
   localparam int IndexW = 10;
   // per-class total over all groups, then a sum over all classes plus a position
   localparam int TotW   = CountW + $clog2(MaxGroups);
   localparam int SumW   = TotW + 3;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_SCAN,
      ST_SUM,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic            capture;
      logic            start;
      logic            rd_scan;
      logic [GrpW-1:0] scan_grp;
      logic [ClsW-1:0] scan_cls;
      logic            check;
      logic            wr;
      logic            add_tot;
      logic [ClsW-1:0] sum_cls;
      logic            set_miss;
      logic            load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic            is_query;
      logic            load_ok;
      logic            hit;
      logic [ClsW-1:0] hit_cls;
   } dp_stat_type;

   function automatic logic [AddrW-1:0] addr_of(input logic [GrpW-1:0] grp,
                                                 input logic [ClsW-1:0] cls);
      addr_of = AddrW'(grp * NumClasses) + AddrW'(cls);
   endfunction

endpackage

/* rtl/bcrim_if.sv */
// Request and response channel interfaces for the blocked class reorder index map
interface bcrim_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [bcrim_pkg::GrpW-1:0]   irrep;
   logic [bcrim_pkg::ClsW-1:0]   orbital_class;
   logic [bcrim_pkg::CountW-1:0] count;
   logic [bcrim_pkg::IndexW-1:0] sym_index;

   modport source (output valid, command, irrep, orbital_class, count, sym_index,
                   input ready);
   modport sink (input valid, command, irrep, orbital_class, count, sym_index,
                 output ready);
endinterface

interface bcrim_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bcrim_pkg::IndexW-1:0] mapped_index;
   logic                         out_of_range;

   modport source (output valid, mapped_index, out_of_range, input ready);
   modport sink (input valid, mapped_index, out_of_range, output ready);
endinterface

/* rtl/bcrim_ctl.sv */
// Controller: sequences loads, the table scan, the class-total sum and the response
module bcrim_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bcrim_pkg::dp_stat_type stat,
   output bcrim_pkg::ctl_cmd_type cmd
);

   bcrim_pkg::state_type state_ff, state_in;
   logic [bcrim_pkg::GrpW-1:0] grp_ff, grp_in;
   logic [bcrim_pkg::ClsW-1:0] cls_ff, cls_in;
   logic                       done_ff, done_in;
   logic                       pend_ff, pend_in;
   logic [bcrim_pkg::ClsW-1:0] sc_ff, sc_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic                       req_acc;
   logic                       issue;

   assign req_acc   = req_valid && (state_ff == bcrim_pkg::ST_IDLE);
   assign req_ready = (state_ff == bcrim_pkg::ST_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign issue     = (state_ff == bcrim_pkg::ST_SCAN) && !done_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcrim_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (stat.is_query) begin
                  state_in = bcrim_pkg::ST_SCAN;
               end else if (stat.load_ok) begin
                  state_in = bcrim_pkg::ST_LOAD_RD;
               end
            end
         end
         bcrim_pkg::ST_LOAD_RD: state_in = bcrim_pkg::ST_LOAD_WR;
         bcrim_pkg::ST_LOAD_WR: state_in = bcrim_pkg::ST_IDLE;
         bcrim_pkg::ST_SCAN: begin
            if (pend_ff && stat.hit) begin
               state_in = bcrim_pkg::ST_SUM;
            end else if (done_ff && !pend_ff) begin
               state_in = bcrim_pkg::ST_FIN;
            end
         end
         bcrim_pkg::ST_SUM: begin
            if (sc_ff == stat.hit_cls) begin
               state_in = bcrim_pkg::ST_FIN;
            end
         end
         bcrim_pkg::ST_FIN: begin
            if (!rsp_vld_ff || rsp_ready) begin
               state_in = bcrim_pkg::ST_IDLE;
            end
         end
         default: state_in = bcrim_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd          = '0;
      cmd.capture  = req_acc;
      cmd.start    = req_acc && stat.is_query;
      cmd.rd_scan  = issue;
      cmd.scan_grp = grp_ff;
      cmd.scan_cls = cls_ff;
      cmd.sum_cls  = sc_ff;
      case (state_ff)
         bcrim_pkg::ST_LOAD_WR: cmd.wr = 1'b1;
         bcrim_pkg::ST_SCAN: begin
            cmd.check    = pend_ff;
            cmd.set_miss = done_ff && !pend_ff;
         end
         bcrim_pkg::ST_SUM: cmd.add_tot = (sc_ff != stat.hit_cls);
         bcrim_pkg::ST_FIN: cmd.load_rsp = !rsp_vld_ff || rsp_ready;
         default: cmd.wr = 1'b0;
      endcase
   end

   // scan counters, sum counter and response flag
   always_comb begin
      grp_in     = grp_ff;
      cls_in     = cls_ff;
      done_in    = done_ff;
      sc_in      = sc_ff;
      rsp_vld_in = rsp_vld_ff;
      // a read is in flight when one was issued and the scan has not hit
      pend_in    = issue && !(pend_ff && stat.hit);
      if (cmd.start) begin
         grp_in  = '0;
         cls_in  = '0;
         done_in = 1'b0;
         sc_in   = '0;
      end else if (issue) begin
         if (cls_ff == bcrim_pkg::ClsW'(bcrim_pkg::NumClasses - 1)) begin
            cls_in = '0;
            if (grp_ff == bcrim_pkg::GrpW'(bcrim_pkg::MaxGroups - 1)) begin
               done_in = 1'b1;
            end else begin
               grp_in = grp_ff + 1'b1;
            end
         end else begin
            cls_in = cls_ff + 1'b1;
         end
      end
      if (cmd.add_tot) begin
         sc_in = sc_ff + 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bcrim_pkg::ST_IDLE;
         grp_ff     <= '0;
         cls_ff     <= '0;
         done_ff    <= 1'b0;
         pend_ff    <= 1'b0;
         sc_ff      <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         grp_ff     <= grp_in;
         cls_ff     <= cls_in;
         done_ff    <= done_in;
         pend_ff    <= pend_in;
         sc_ff      <= sc_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

endmodule

/* rtl/bcrim_dp.sv */
// Datapath: count table memory, class totals, scan accumulators and response register
module bcrim_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  bcrim_pkg::ctl_cmd_type       cmd,
   output bcrim_pkg::dp_stat_type       stat,
   input  logic                         req_command,
   input  logic [bcrim_pkg::GrpW-1:0]   req_irrep,
   input  logic [bcrim_pkg::ClsW-1:0]   req_orbital_class,
   input  logic [bcrim_pkg::CountW-1:0] req_count,
   input  logic [bcrim_pkg::IndexW-1:0] req_sym_index,
   output logic [bcrim_pkg::IndexW-1:0] rsp_mapped_index,
   output logic                         rsp_out_of_range
);

   logic [bcrim_pkg::CountW-1:0] mem [bcrim_pkg::TableDepth];
   logic [bcrim_pkg::TableDepth-1:0] vld_ff;

   logic [bcrim_pkg::GrpW-1:0]   grp_ff;
   logic [bcrim_pkg::ClsW-1:0]   cls_ff;
   logic [bcrim_pkg::CountW-1:0] cnt_ff;
   logic [bcrim_pkg::CountW-1:0] rd_data_ff;
   logic                         rd_vld_ff;
   logic [bcrim_pkg::ClsW-1:0]   rd_cls_ff;
   logic [bcrim_pkg::IndexW-1:0] pos_ff;
   logic [bcrim_pkg::TotW-1:0]   acc_ff [bcrim_pkg::NumClasses];
   logic [bcrim_pkg::TotW-1:0]   tot_ff [bcrim_pkg::NumClasses];
   logic [bcrim_pkg::SumW-1:0]   mapped_ff;
   logic                         miss_ff;
   logic [bcrim_pkg::ClsW-1:0]   hit_cls_ff;
   logic [bcrim_pkg::IndexW-1:0] rsp_idx_ff;
   logic                         rsp_oor_ff;

   logic [bcrim_pkg::AddrW-1:0]  item_addr;
   logic [bcrim_pkg::AddrW-1:0]  rd_addr;
   logic [bcrim_pkg::CountW-1:0] n;
   logic                         hit;
   logic [bcrim_pkg::ClsW-1:0]   tot_idx;
   logic [bcrim_pkg::TotW-1:0]   tot_rd;
   logic                         oor;

   assign item_addr = bcrim_pkg::addr_of(grp_ff, cls_ff);
   assign rd_addr   = cmd.rd_scan ? bcrim_pkg::addr_of(cmd.scan_grp, cmd.scan_cls)
                                  : item_addr;
   // never-written entries read as zero
   assign n         = rd_vld_ff ? rd_data_ff : '0;
   assign hit       = {1'b0, pos_ff} < n;
   assign tot_idx   = cmd.add_tot ? cmd.sum_cls : cls_ff;
   assign tot_rd    = tot_ff[tot_idx];
   assign oor       = miss_ff || (mapped_ff >= bcrim_pkg::SumW'(bcrim_pkg::MaxOrbitals));

   assign stat.is_query = (req_command == bcrim_pkg::CMD_QUERY);
   assign stat.load_ok  = ({1'b0, req_irrep} < (bcrim_pkg::GrpW + 1)'(bcrim_pkg::MaxGroups))
                       && (req_orbital_class < bcrim_pkg::ClsW'(bcrim_pkg::NumClasses));
   assign stat.hit      = hit;
   assign stat.hit_cls  = hit_cls_ff;

   assign rsp_mapped_index = rsp_idx_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // table memory: one read and one write port, registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      rd_cls_ff  <= cmd.scan_cls;
      if (cmd.wr) begin
         mem[item_addr] <= cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (cmd.wr) begin
            vld_ff[item_addr] <= 1'b1;
         end
      end
   end

   // class totals over all groups: swap the old count for the new one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bcrim_pkg::NumClasses; i++) begin
            tot_ff[i] <= '0;
         end
      end else if (cmd.wr) begin
         tot_ff[cls_ff] <= tot_rd - bcrim_pkg::TotW'(n) + bcrim_pkg::TotW'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         grp_ff <= req_irrep;
         cls_ff <= req_orbital_class;
         cnt_ff <= req_count;
      end
      if (cmd.start) begin
         pos_ff    <= req_sym_index;
         mapped_ff <= '0;
         miss_ff   <= 1'b0;
         for (int i = 0; i < bcrim_pkg::NumClasses; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (cmd.check) begin
         if (hit) begin
            mapped_ff  <= bcrim_pkg::SumW'(pos_ff) + bcrim_pkg::SumW'(acc_ff[rd_cls_ff]);
            hit_cls_ff <= rd_cls_ff;
         end else begin
            // pos is not below n here, so n fits the index width
            pos_ff            <= pos_ff - n[bcrim_pkg::IndexW-1:0];
            acc_ff[rd_cls_ff] <= acc_ff[rd_cls_ff] + bcrim_pkg::TotW'(n);
         end
      end else if (cmd.add_tot) begin
         mapped_ff <= mapped_ff + bcrim_pkg::SumW'(tot_rd);
      end
      if (cmd.set_miss) begin
         miss_ff <= 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_oor_ff <= oor;
         rsp_idx_ff <= oor ? '0 : mapped_ff[bcrim_pkg::IndexW-1:0];
      end
   end

endmodule

/* rtl/blocked_class_reorder_index_map.sv */
// Top level of the blocked class reorder index map
// Holds a count per group and class (8 groups x 5 classes, all zero after reset) and maps
// a group-major orbital index to its class-major index. A load item goes through accept,
// read of the old count and write so the running per-class totals stay current; a load
// to a group or class outside the table is dropped at once and gives no response. A query
// walks the table in group-major order through the single read port of the count memory,
// one entry per cycle, until it finds the block holding the index, then adds the totals
// of the earlier classes one per cycle. An index at or past the total, or a mapped
// index that would reach 1024, returns out_of_range with a mapped index of 0. The
// response sits in an output register, so the next item is accepted while it waits.
`include "blocked_class_reorder_index_map_macros.svh"

module blocked_class_reorder_index_map (
   input  logic        clock,
   input  logic        reset,
   bcrim_req_if.sink   req_chan,
   bcrim_rsp_if.source rsp_chan
);

   bcrim_pkg::ctl_cmd_type ctl_cmd;
   bcrim_pkg::dp_stat_type dp_stat;
   logic                   load_idle;
   logic                   oor_bad;
   logic                   busy;
   logic                   both_ops;

   bcrim_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   bcrim_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (ctl_cmd),
      .stat              (dp_stat),
      .req_command       (req_chan.command),
      .req_irrep         (req_chan.irrep),
      .req_orbital_class (req_chan.orbital_class),
      .req_count         (req_chan.count),
      .req_sym_index     (req_chan.sym_index),
      .rsp_mapped_index  (rsp_chan.mapped_index),
      .rsp_out_of_range  (rsp_chan.out_of_range)
   );

   assign load_idle = req_chan.valid && req_chan.ready
                   && (req_chan.command == bcrim_pkg::CMD_LOAD) && !rsp_chan.valid;
   assign oor_bad   = rsp_chan.valid && rsp_chan.out_of_range
                   && (rsp_chan.mapped_index != '0);
   assign busy      = ctl_cmd.check || ctl_cmd.add_tot || ctl_cmd.wr;
   assign both_ops  = ctl_cmd.check && ctl_cmd.add_tot;

   `BCRIM_ASSERT(a_load_no_rsp, clock, reset, load_idle |=> !rsp_chan.valid, "load item answered")
   `BCRIM_ASSERT_NEVER(a_oor_zero, clock, reset, oor_bad, "nonzero index out of range")
   `BCRIM_ASSERT(a_busy_no_accept, clock, reset, busy |-> !req_chan.ready, "accept while busy")
   `BCRIM_ASSERT_NEVER(a_scan_sum_excl, clock, reset, both_ops, "check and add together")

endmodule
